>>> src/float_add_sub_mul_div_unit_defines.svh
// Assertion macros shared by the arithmetic unit.
`ifndef FLOAT_ADD_SUB_MUL_DIV_UNIT_DEFINES_SVH
`define FLOAT_ADD_SUB_MUL_DIV_UNIT_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define FAU_ASSERT_IMPL(label, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define FAU_ASSERT_NEXT(label, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error(msg);

`endif

>>> src/fau_pkg.sv
// Package with shared types and constants of the arithmetic unit.
package fau_pkg;

  localparam int unsigned QuotW = 26;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } fau_op_t;

  // Sign and exponent side band that travels with the divider.
  typedef struct packed {
    logic       sign;
    logic [7:0] exp_keep;
    logic [7:0] exp_less;
    logic       less;
  } fau_div_side_t;

endpackage

>>> src/fau_if.sv
// Valid/ready channel interfaces of the arithmetic unit.
interface fau_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] operand_a;
  logic [31:0] operand_b;
  modport source (output valid, kind, operand_a, operand_b, input ready);
  modport sink (input valid, kind, operand_a, operand_b, output ready);
endinterface

interface fau_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result;
  modport source (output valid, result, input ready);
  modport sink (input valid, result, output ready);
endinterface

>>> src/fau_div_stage.sv
// One pipelined restoring-division step over two quotient bits.
module fau_div_stage
  import fau_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [24:0] rem_i,
  input  logic [23:0] den_i,
  input  logic [47:0] num_i,
  input  logic [25:0] quot_i,
  output logic [24:0] rem_o,
  output logic [23:0] den_o,
  output logic [47:0] num_o,
  output logic [25:0] quot_o
);

  logic [25:0] t0;
  logic [24:0] r0;
  logic [25:0] t1;
  logic [24:0] r1;
  logic        q0;
  logic        q1;

  // Two shift-compare-subtract steps; the remainder stays below the divisor.
  always_comb begin
    t0 = {rem_i, num_i[47]};
    q0 = (t0 >= {2'b00, den_i});
    r0 = q0 ? 25'(t0 - {2'b00, den_i}) : t0[24:0];
    t1 = {r0, num_i[46]};
    q1 = (t1 >= {2'b00, den_i});
    r1 = q1 ? 25'(t1 - {2'b00, den_i}) : t1[24:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o  <= r1;
      den_o  <= den_i;
      num_o  <= {num_i[45:0], 2'b00};
      quot_o <= {quot_i[QuotW-3:0], q0, q1};
    end
  end

endmodule

>>> src/fau_addsub.sv
// Combinational add/subtract datapath split across the unit pipeline.
module fau_addsub
  import fau_pkg::*;
(
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic        negate_b,
  output logic        sign_o,
  output logic [8:0]  inc_o,
  output logic [24:0] sum_o
);

  logic        sa;
  logic        sb;
  logic [7:0]  ea;
  logic [7:0]  eb;
  logic [23:0] fa;
  logic [23:0] fb;
  logic        a_big;
  logic [7:0]  diff;
  logic [23:0] sha;
  logic [23:0] shb;
  logic [24:0] big;
  logic [24:0] sml;

  // Align the smaller operand and add or subtract in 25 bits.
  always_comb begin
    sa    = a[31];
    sb    = b[31] ^ negate_b;
    ea    = a[30:23];
    eb    = b[30:23];
    fa    = {1'b1, a[22:0]};
    fb    = {1'b1, b[22:0]};
    a_big = (a[30:0] > b[30:0]);
    diff  = (ea > eb) ? 8'(ea - eb) : 8'(eb - ea);
    sha   = (ea != 8'd0) ? (fa >> diff) : 24'd0;
    shb   = (eb != 8'd0) ? (fb >> diff) : 24'd0;
    big   = {1'b0, a_big ? fa : fb};
    sml   = {1'b0, a_big ? shb : sha};
    sign_o = a_big ? sa : sb;
    inc_o  = 9'({1'b0, a_big ? ea : eb} + 9'd1);
    sum_o  = (sa != sb) ? 25'(big - sml) : 25'(big + sml);
  end

endmodule

>>> src/float_add_sub_mul_div_unit.sv
// Top level: pipelined single-precision add, subtract, multiply and divide.
// Throughput: one request per cycle unless the output stalls; the 12-stage radix-4 divider pipe sets depth.
// A stall freezes all stages together; the output register holds the result.
// Reset (synchronous, active low) clears all valid bits; payload is not reset.
module float_add_sub_mul_div_unit
  import fau_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  fau_in_if.sink    in_ch,
  fau_out_if.source out_ch
);

`include "float_add_sub_mul_div_unit_defines.svh"

  localparam int unsigned Depth = 15;
  localparam int unsigned DivSt = 12;

  logic              en;
  logic [Depth-1:0]  vld_r;
  fau_op_t           op_r [Depth];
  logic [31:0]       res_r [2:Depth-1];

  // Stage 1 registers.
  logic [31:0] a1_r, b1_r;
  // Add/sub intermediate.
  logic        as_sign;
  logic [8:0]  as_inc;
  logic [24:0] as_sum;
  logic        as_sign_r;
  logic [8:0]  as_inc_r;
  logic [24:0] as_sum_r;
  // Multiply partial products.
  logic [25:0] hh_r;
  logic [23:0] hl_r, lh_r;
  logic [8:0]  me0_r;
  logic        mnz_r, msign_r;
  // Divider pipe.
  logic [24:0] rem [DivSt+1];
  logic [23:0] den [DivSt+1];
  logic [47:0] num [DivSt+1];
  logic [25:0] quo [DivSt+1];
  fau_div_side_t side_d;
  fau_div_side_t side_r [1:DivSt];

  assign en          = out_ch.ready || !out_ch.valid;
  assign in_ch.ready = en;
  assign out_ch.valid = vld_r[Depth-1];
  assign out_ch.result = res_r[Depth-1];

  // Valid bits move with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[Depth-2:0], in_ch.valid};
    end
  end

  // Stage 0 to 1: capture operands.
  always_ff @(posedge clk) begin
    if (en) begin
      op_r[0] <= fau_op_t'(in_ch.kind);
      a1_r    <= in_ch.operand_a;
      b1_r    <= in_ch.operand_b;
    end
  end

  fau_addsub u_addsub (
    .a        (a1_r),
    .b        (b1_r),
    .negate_b (op_r[0] == OP_SUB),
    .sign_o   (as_sign),
    .inc_o    (as_inc),
    .sum_o    (as_sum)
  );

  // Stage 1 to 2: align-add and multiplier partial products; divider setup.
  always_ff @(posedge clk) begin
    if (en) begin
      op_r[1]   <= op_r[0];
      as_sign_r <= as_sign;
      as_inc_r  <= as_inc;
      as_sum_r  <= as_sum;
      hh_r      <= 26'({1'b1, a1_r[22:11]} * {1'b1, b1_r[22:11]});
      hl_r      <= 24'({1'b1, a1_r[22:11]} * b1_r[10:0]);
      lh_r      <= 24'(a1_r[10:0] * {1'b1, b1_r[22:11]});
      me0_r     <= 9'({1'b0, a1_r[30:23]} + {1'b0, b1_r[30:23]} + 9'd129);
      mnz_r     <= (a1_r[30:23] != 8'd0) && (b1_r[30:23] != 8'd0);
      msign_r   <= a1_r[31] ^ b1_r[31];
    end
  end

  // Divider input: quotient bits come from the shifted 48-bit dividend.
  logic        dless;
  logic [8:0]  de1;
  logic [8:0]  de2;
  logic [47:0] dnum;
  always_comb begin
    dless = a1_r[22:0] < b1_r[22:0];
    de1 = 9'({1'b0, a1_r[30:23]} + 9'd383 - {1'b0, b1_r[30:23]});
    de2 = 9'(de1 - 9'd1);
  end

  assign dnum   = dless ? {1'b1, a1_r[22:0], 24'd0} : {1'b0, 1'b1, a1_r[22:0], 23'd0};
  // The upper dividend half is always below the divisor, so it seeds the remainder
  // and only the lower half needs division steps.
  assign rem[0] = {1'b0, dnum[47:24]};
  assign den[0] = {1'b1, b1_r[22:0]};
  assign num[0] = {dnum[23:0], 24'd0};
  assign quo[0] = 26'd0;
  always_comb begin
    side_d.sign     = a1_r[31] ^ b1_r[31];
    side_d.less     = dless;
    side_d.exp_keep = (de1[8] && a1_r[30:23] != 8'd0) ? de1[7:0] : 8'd0;
    side_d.exp_less = (de1[8] && a1_r[30:23] != 8'd0) ? de2[7:0] : 8'd0;
  end

  for (genvar g = 0; g < DivSt; g++) begin : g_div
    fau_div_stage u_stage (
      .clk    (clk),
      .en     (en),
      .rem_i  (rem[g]),
      .den_i  (den[g]),
      .num_i  (num[g]),
      .quot_i (quo[g]),
      .rem_o  (rem[g+1]),
      .den_o  (den[g+1]),
      .num_o  (num[g+1]),
      .quot_o (quo[g+1])
    );
    if (g == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en) begin
          side_r[1] <= side_d;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en) begin
          side_r[g+1] <= side_r[g];
        end
      end
    end
  end

  // Stage 2 to 3: normalize the sum and finish the product.
  logic [4:0]  lz;
  logic        lz_none;
  logic [24:0] norm;
  logic [8:0]  ae;
  logic [31:0] as_res;
  logic [25:0] prod;
  logic        top;
  logic [8:0]  me1;
  logic [7:0]  mey;
  logic [31:0] mul_res;
  always_comb begin
    lz = 5'd0;
    lz_none = 1'b1;
    for (int i = 24; i >= 0; i--) begin
      if (lz_none && as_sum_r[i]) begin
        lz = 5'(24 - i);
        lz_none = 1'b0;
      end
    end
    norm = lz_none ? 25'd0 : 25'(as_sum_r << lz);
    ae   = 9'(as_inc_r - {4'd0, lz});
    as_res = {as_sign_r, (lz_none || ae[8]) ? 8'd0 : ae[7:0], norm[23:1]};
    prod = 26'(hh_r + {13'd0, hl_r[23:11]} + {13'd0, lh_r[23:11]} + 26'd2);
    top  = prod[25];
    me1  = 9'(me0_r + 9'd1);
    mey  = (me0_r[8] && mnz_r) ? (top ? me1[7:0] : me0_r[7:0]) : 8'd0;
    mul_res = {msign_r, mey, top ? prod[24:2] : prod[23:1]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op_r[2]  <= op_r[1];
      res_r[2] <= (op_r[1] == OP_MUL) ? mul_res : as_res;
    end
  end

  // Carry add/sub/mul results to the output register; divide results join after the last divider stage.
  for (genvar k = 3; k < Depth; k++) begin : g_delay
    always_ff @(posedge clk) begin
      if (en) begin
        op_r[k]  <= op_r[k-1];
        res_r[k] <= (k == DivSt + 1 && op_r[k-1] == OP_DIV) ?
                    {side_r[DivSt].sign,
                     side_r[DivSt].less ? side_r[DivSt].exp_less : side_r[DivSt].exp_keep,
                     quo[DivSt][22:0]} : res_r[k-1];
      end
    end
  end

  // The pipe never advances while a waiting result is stalled.
  `FAU_ASSERT_NEXT(a_hold, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.result), "stalled result changed")
  `FAU_ASSERT_IMPL(a_ready, out_ch.valid && !out_ch.ready, !in_ch.ready, "input taken during stall")
  `FAU_ASSERT_NEXT(a_flow, in_ch.ready && !in_ch.valid, !vld_r[0], "bubble became valid")

endmodule
